// ----- rtl/bcs_pkg.sv -----
`default_nettype none
package bcs_pkg;

	localparam int FRAC_BITS_DEF  = 12;
	localparam int COMP_WIDTH_DEF = 16;
	localparam int OUT_WIDTH      = 24;
	localparam int IN_WIDTH       = 16;

	typedef struct packed {
		logic signed [IN_WIDTH-1:0] target_x;
		logic signed [IN_WIDTH-1:0] target_y;
		logic signed [IN_WIDTH-1:0] target_z;
		logic signed [IN_WIDTH-1:0] basis_a_x;
		logic signed [IN_WIDTH-1:0] basis_a_y;
		logic signed [IN_WIDTH-1:0] basis_a_z;
		logic signed [IN_WIDTH-1:0] basis_b_x;
		logic signed [IN_WIDTH-1:0] basis_b_y;
		logic signed [IN_WIDTH-1:0] basis_b_z;
		logic signed [IN_WIDTH-1:0] basis_c_x;
		logic signed [IN_WIDTH-1:0] basis_c_y;
		logic signed [IN_WIDTH-1:0] basis_c_z;
	} in_item_t;

	typedef struct packed {
		logic signed [OUT_WIDTH-1:0] coord_a;
		logic signed [OUT_WIDTH-1:0] coord_b;
		logic signed [OUT_WIDTH-1:0] coord_c;
		logic                        singular;
		logic                        saturated;
	} out_item_t;

endpackage
`default_nettype wire

// ----- rtl/bcs_fifo.sv -----
`default_nettype none
module bcs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH_LOG2 = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             rd,
	output logic                  ne,
	output logic [WIDTH-1:0]      rdata,
	output logic [DEPTH_LOG2:0]   count
);
	localparam int DEPTH = 1 << DEPTH_LOG2;

	logic [WIDTH-1:0]      mem_q [DEPTH];
	logic [DEPTH_LOG2-1:0] wp_q, rp_q;
	logic [DEPTH_LOG2:0]   mcnt_q;
	logic                  ov_q;
	logic [WIDTH-1:0]      rdata_q;
	logic                  ld, from_mem, bypass, mem_wr;

	// output register takes the oldest beat, straight from the input when the memory is empty
	assign ld       = !ov_q || rd;
	assign from_mem = ld && (mcnt_q != '0);
	assign bypass   = ld && (mcnt_q == '0) && wr;
	assign mem_wr   = wr && !bypass;

	// pointer, count and output valid update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			mcnt_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (mem_wr)   wp_q <= wp_q + 1'b1;
			if (from_mem) rp_q <= rp_q + 1'b1;
			mcnt_q <= mcnt_q + (DEPTH_LOG2+1)'(mem_wr) - (DEPTH_LOG2+1)'(from_mem);
			if (ld)       ov_q <= from_mem || bypass;
		end
	end

	// storage with registered read
	always_ff @(posedge clk) begin
		if (mem_wr) mem_q[wp_q] <= wdata;
		if (from_mem)    rdata_q <= mem_q[rp_q];
		else if (bypass) rdata_q <= wdata;
	end

	assign rdata = rdata_q;
	assign ne    = ov_q;
	assign count = mcnt_q + (DEPTH_LOG2+1)'(ov_q);
endmodule
`default_nettype wire

// ----- rtl/bcs_front.sv -----
`default_nettype none
// computes the determinant and three numerators, classifies singular items
module bcs_front
	import bcs_pkg::*;
#(
	parameter int DW = 3 * IN_WIDTH + 3
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_vld,
	input  wire in_item_t             in_item,
	output logic                      vld_s4,
	output logic signed [DW-1:0]      det_s4,
	output logic signed [DW-1:0]      na_s4,
	output logic signed [DW-1:0]      nb_s4,
	output logic signed [DW-1:0]      nc_s4,
	output logic                      sing_s4
);
	localparam int CW = IN_WIDTH;
	localparam int PW = 2 * CW;
	localparam int TW = 3 * CW;

	logic signed [CW-1:0] t[3], a[3], b[3], c[3];
	assign t[0] = CW'(in_item.target_x);
	assign t[1] = CW'(in_item.target_y);
	assign t[2] = CW'(in_item.target_z);
	assign a[0] = CW'(in_item.basis_a_x);
	assign a[1] = CW'(in_item.basis_a_y);
	assign a[2] = CW'(in_item.basis_a_z);
	assign b[0] = CW'(in_item.basis_b_x);
	assign b[1] = CW'(in_item.basis_b_y);
	assign b[2] = CW'(in_item.basis_b_z);
	assign c[0] = CW'(in_item.basis_c_x);
	assign c[1] = CW'(in_item.basis_c_y);
	assign c[2] = CW'(in_item.basis_c_z);

	// stage 1: 2x2 minors as products; det = u0*(v1w2-v2w1) - v0*(u1w2-u2w1) + w0*(u1v2-u2v1)
	// minors of (b,c), (a,c), (a,b), (t,c), (t,b), (a,t), (b,t)
	logic                  vld_s1;
	logic signed [PW-1:0]  p_s1 [14];
	logic signed [CW-1:0]  k_s1 [4];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= in_vld;
	end
	always_ff @(posedge clk) begin
		p_s1[0]  <= b[1]*c[2]; p_s1[1]  <= b[2]*c[1];
		p_s1[2]  <= a[1]*c[2]; p_s1[3]  <= a[2]*c[1];
		p_s1[4]  <= a[1]*b[2]; p_s1[5]  <= a[2]*b[1];
		p_s1[6]  <= t[1]*c[2]; p_s1[7]  <= t[2]*c[1];
		p_s1[8]  <= t[1]*b[2]; p_s1[9]  <= t[2]*b[1];
		p_s1[10] <= a[1]*t[2]; p_s1[11] <= a[2]*t[1];
		p_s1[12] <= b[1]*t[2]; p_s1[13] <= b[2]*t[1];
		k_s1[0] <= t[0];
		k_s1[1] <= a[0];
		k_s1[2] <= b[0];
		k_s1[3] <= c[0];
	end

	// stage 2: minors
	logic                    vld_s2;
	logic signed [PW:0]      m_s2 [7];
	logic signed [CW-1:0]    k_s2 [4];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else         vld_s2 <= vld_s1;
	end
	always_ff @(posedge clk) begin
		for (int i = 0; i < 7; i++)
			m_s2[i] <= (PW+1)'(p_s1[2*i]) - (PW+1)'(p_s1[2*i+1]);
		k_s2 <= k_s1;
	end

	// stage 3: cofactor products
	// det = a0*Mbc - b0*Mac + c0*Mab
	// na  = t0*Mbc - b0*Mtc + c0*Mtb
	// nb  = a0*Mtc - t0*Mac + c0*Mat   (Mat = a1t2-a2t1)
	// nc  = a0*Mbt - b0*Mat + t0*Mab   (Mbt = b1t2-b2t1)
	logic                  vld_s3;
	logic signed [TW:0]    q_s3 [12];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else         vld_s3 <= vld_s2;
	end
	always_ff @(posedge clk) begin
		q_s3[0]  <= k_s2[1] * m_s2[0];
		q_s3[1]  <= k_s2[2] * m_s2[1];
		q_s3[2]  <= k_s2[3] * m_s2[2];
		q_s3[3]  <= k_s2[0] * m_s2[0];
		q_s3[4]  <= k_s2[2] * m_s2[3];
		q_s3[5]  <= k_s2[3] * m_s2[4];
		q_s3[6]  <= k_s2[1] * m_s2[3];
		q_s3[7]  <= k_s2[0] * m_s2[1];
		q_s3[8]  <= k_s2[3] * m_s2[5];
		q_s3[9]  <= k_s2[1] * m_s2[6];
		q_s3[10] <= k_s2[2] * m_s2[5];
		q_s3[11] <= k_s2[0] * m_s2[2];
	end

	// stage 4: sums and singular check
	logic signed [DW-1:0] dsum;
	assign dsum = DW'(q_s3[0]) - DW'(q_s3[1]) + DW'(q_s3[2]);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else         vld_s4 <= vld_s3;
	end
	always_ff @(posedge clk) begin
		det_s4  <= dsum;
		sing_s4 <= dsum == '0;
		na_s4   <= DW'(q_s3[3]) - DW'(q_s3[4]) + DW'(q_s3[5]);
		nb_s4   <= DW'(q_s3[6]) - DW'(q_s3[7]) + DW'(q_s3[8]);
		nc_s4   <= DW'(q_s3[9]) - DW'(q_s3[10]) + DW'(q_s3[11]);
	end
endmodule
`default_nettype wire

// ----- rtl/bcs_back.sv -----
`default_nettype none
// pipelined restoring division, one quotient bit per stage, three lanes
module bcs_back
	import bcs_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int DW = 3 * COMP_WIDTH_DEF + 3
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_vld,
	input  wire logic [DW-1:0]     det,
	input  wire logic [DW-1:0]     na,
	input  wire logic [DW-1:0]     nb,
	input  wire logic [DW-1:0]     nc,
	input  wire logic              sing,
	output logic                   out_vld,
	output out_item_t              out_item
);
	// quotient bits needed: OUT_WIDTH magnitude bits plus rounding plus one overflow guard
	localparam int QB  = OUT_WIDTH + 2;
	localparam int NS  = DW + FRAC_BITS + 1;
	localparam int RW  = DW + 1;

	// stage 0: magnitudes and scaled numerators for the overflow test
	// the quotient exceeds QB bits iff n >= d << QB
	logic              vld0;
	logic [DW-1:0]     d0;
	logic [NS-1:0]     n0 [3];
	logic              neg0 [3];
	logic              sing0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld0 <= 1'b0;
		else         vld0 <= in_vld;
	end
	always_ff @(posedge clk) begin
		d0    <= det[DW-1] ? DW'(-det) : det;
		sing0 <= sing;
		neg0[0] <= na[DW-1] ^ det[DW-1];
		neg0[1] <= nb[DW-1] ^ det[DW-1];
		neg0[2] <= nc[DW-1] ^ det[DW-1];
		n0[0] <= {(na[DW-1] ? DW'(-na) : na), (FRAC_BITS+1)'(0)};
		n0[1] <= {(nb[DW-1] ? DW'(-nb) : nb), (FRAC_BITS+1)'(0)};
		n0[2] <= {(nc[DW-1] ? DW'(-nc) : nc), (FRAC_BITS+1)'(0)};
	end

	// division stages
	logic              v_q [QB+1];
	logic [DW-1:0]     d_q [QB+1];
	logic [NS-1:0]     n_q [QB+1][3];
	logic [RW-1:0]     r_q [QB+1][3];
	logic [QB-1:0]     q_q [QB+1][3];
	logic              ng_q [QB+1][3], bg_q [QB+1][3];
	logic              sg_q [QB+1];

	// overflow stage: compare top part against d, load the first division stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q[0] <= 1'b0;
		else         v_q[0] <= vld0;
	end
	always_ff @(posedge clk) begin
		d_q[0] <= d0; sg_q[0] <= sing0;
		for (int l = 0; l < 3; l++) begin
			n_q[0][l]  <= n0[l];
			r_q[0][l]  <= RW'(n0[l] >> QB);
			q_q[0][l]  <= '0;
			ng_q[0][l] <= neg0[l];
			bg_q[0][l] <= (NS+1)'(n0[l] >> QB) >= (NS+1)'(d0);
		end
	end

	for (genvar s = 0; s < QB; s++) begin : g_div
		logic [RW-1:0] tr [3];
		logic          ge [3];
		always_comb begin
			for (int l = 0; l < 3; l++) begin
				tr[l] = {r_q[s][l][RW-2:0], n_q[s][l][QB-1-s]};
				ge[l] = tr[l] >= RW'(d_q[s]);
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q[s+1] <= 1'b0;
			else         v_q[s+1] <= v_q[s];
		end
		always_ff @(posedge clk) begin
			d_q[s+1]  <= d_q[s];
			sg_q[s+1] <= sg_q[s];
			for (int l = 0; l < 3; l++) begin
				n_q[s+1][l]  <= n_q[s][l];
				r_q[s+1][l]  <= ge[l] ? tr[l] - RW'(d_q[s]) : tr[l];
				q_q[s+1][l]  <= {q_q[s][l][QB-2:0], ge[l]};
				ng_q[s+1][l] <= ng_q[s][l];
				bg_q[s+1][l] <= bg_q[s][l];
			end
		end
	end

	// rounding and saturation
	localparam logic [QB-1:0] LIM_P = QB'((1 << (OUT_WIDTH-1)) - 1);
	localparam logic [QB-1:0] LIM_N = QB'(1 << (OUT_WIDTH-1));
	logic [QB-1:0]          mag [3], lim [3];
	logic                   sat [3];
	logic [OUT_WIDTH-1:0]   cv [3];
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			mag[l] = QB'(({1'b0, q_q[QB][l]} + 1'b1) >> 1);
			lim[l] = ng_q[QB][l] ? LIM_N : LIM_P;
			sat[l] = bg_q[QB][l] || mag[l] > lim[l];
			cv[l]  = sat[l] ? OUT_WIDTH'(ng_q[QB][l] ? -lim[l] : lim[l])
			                : OUT_WIDTH'(ng_q[QB][l] ? -mag[l] : mag[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld <= 1'b0;
		else         out_vld <= v_q[QB];
	end
	always_ff @(posedge clk) begin
		out_item.singular  <= sg_q[QB];
		out_item.coord_a   <= sg_q[QB] ? '0 : cv[0];
		out_item.coord_b   <= sg_q[QB] ? '0 : cv[1];
		out_item.coord_c   <= sg_q[QB] ? '0 : cv[2];
		out_item.saturated <= !sg_q[QB] && (sat[0] || sat[1] || sat[2]);
	end
endmodule
`default_nettype wire

// ----- rtl/basis_change_3x3_solve.sv -----
`default_nettype none
// 34 register stages lie between an accepted beat and the output queue register
// (4 determinant front, 2+OUT_WIDTH+2+1 division, 1 output queue register)
// throughput: one item per cycle through the determinant and divider pipelines while full is low
// full rises when in-flight items could overrun the output queue
// reset clears the valid pipeline and the queue pointers; payload is not reset
module basis_change_3x3_solve
	import bcs_pkg::*;
#(
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	output logic           full,
	input  wire in_item_t  in_item,
	output logic           empty,
	input  wire logic      pop,
	output out_item_t      out_item
);
	localparam int DW  = 3 * IN_WIDTH + 3;
	localparam int LAT = 4 + 1 + OUT_WIDTH + 2 + 1 + 1;
	localparam int QL2 = $clog2(LAT + 4);
	localparam int QD  = 1 << QL2;

	logic          acc;
	logic          f_vld, b_vld, sing;
	logic [DW-1:0] det, na, nb, nc;
	out_item_t     b_item;
	logic          ne;
	logic [QL2:0]  cnt;
	logic [QL2:0]  fly_q;

	assign acc = push && !full;

	// beats in flight reserve queue room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fly_q <= '0;
		else         fly_q <= fly_q + (QL2+1)'(acc) - (QL2+1)'(b_vld);
	end
	assign full = (QL2+2)'(fly_q) + (QL2+2)'(cnt) >= (QL2+2)'(QD);

	bcs_front #(.DW(DW)) u_front (
		.clk, .arst_n, .in_vld(acc), .in_item,
		.vld_s4(f_vld), .det_s4(det), .na_s4(na), .nb_s4(nb), .nc_s4(nc), .sing_s4(sing)
	);

	bcs_back #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_back (
		.clk, .arst_n, .in_vld(f_vld), .det, .na, .nb, .nc, .sing,
		.out_vld(b_vld), .out_item(b_item)
	);

	bcs_fifo #(.WIDTH($bits(out_item_t)), .DEPTH_LOG2(QL2)) u_q (
		.clk, .arst_n, .wr(b_vld), .wdata(b_item), .rd(pop && ne),
		.ne, .rdata(out_item), .count(cnt)
	);

	assign empty = !ne;
endmodule
`default_nettype wire
